@@ sv/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types for the triangle plane section pipeline.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Source of one segment end point: a vertex or the crossing of an edge
  typedef enum logic [2:0] {
    PT_VA,
    PT_VB,
    PT_VC,
    PT_AB,
    PT_BC,
    PT_CA
  } tps_pt_t;

  // Per-stage flow control that travels beside the data
  typedef struct packed {
    logic vld;
    logic hit;
  } tps_flow_t;

endpackage

@@ sv/triangle_plane_section_core.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_section_core
// Cuts one triangle, given in the frame of the plane z = 0, with that plane.
// ----------------------------------------------------------------------------
// Input channel in_*: one triangle per transaction, nine signed fixed-point
// coordinates packed in in_tdata (a, b, c; x, y, z each).
// Output channel out_*: one result per triangle. out_tuser is the hit flag;
// out_tdata holds start x, start y, end x, end y, all zero on a miss.
// A crossing is interpolated from the edge's negative-z end with the
// quotient truncated toward zero.
// Stages: classify, edge select, multiply, one divider stage per quotient
// bit, final add; throughput is one triangle per cycle while out_tready
// allows, set by the fully pipelined multiply and restoring divider.
// Reset clears all valid bits; the pipe is empty after rst_n is released.
// When out_tready is low with a result waiting, the whole pipe holds and
// in_tready drops until that result is taken; empty slots hold with it.
// ----------------------------------------------------------------------------
module triangle_plane_section_core #(
  parameter int COORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z; zero fill to bytes
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y; zero fill to bytes
  output logic [((4*COORD_BITS+7)/8)*8-1:0]     out_tdata,
  // hit
  output logic                                  out_tuser
);

  localparam int W       = COORD_BITS;
  localparam int LAT     = W + 2;
  localparam int OUT_W   = ((4*W+7)/8)*8;

  tps_pkg::tps_flow_t flow_sel;
  tps_pkg::tps_flow_t flow_r [LAT];
  logic               adv;

  logic [W-1:0] base_x [2], base_y [2], mag_x [2], mag_y [2], num [2], den [2];
  logic         neg_x  [2], neg_y  [2];
  logic [W-1:0] res_x  [2], res_y  [2];

  // advance when the output slot is empty or being taken
  assign adv       = !flow_r[LAT-1].vld || out_tready;
  assign in_tready = adv;

  tps_select #(.W(W)) u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_tvalid),
    .a_x    (in_tdata[0*W +: W]),
    .a_y    (in_tdata[1*W +: W]),
    .a_z    (in_tdata[2*W +: W]),
    .b_x    (in_tdata[3*W +: W]),
    .b_y    (in_tdata[4*W +: W]),
    .b_z    (in_tdata[5*W +: W]),
    .c_x    (in_tdata[6*W +: W]),
    .c_y    (in_tdata[7*W +: W]),
    .c_z    (in_tdata[8*W +: W]),
    .flow   (flow_sel),
    .base_x (base_x),
    .base_y (base_y),
    .neg_x  (neg_x),
    .neg_y  (neg_y),
    .mag_x  (mag_x),
    .mag_y  (mag_y),
    .num    (num),
    .den    (den)
  );

  for (genvar l = 0; l < 2; l++) begin : g_pt
    tps_interp #(.W(W)) u_ix (
      .clk  (clk),
      .adv  (adv),
      .base (base_x[l]),
      .neg  (neg_x[l]),
      .mag  (mag_x[l]),
      .num  (num[l]),
      .den  (den[l]),
      .res  (res_x[l])
    );
    tps_interp #(.W(W)) u_iy (
      .clk  (clk),
      .adv  (adv),
      .base (base_y[l]),
      .neg  (neg_y[l]),
      .mag  (mag_y[l]),
      .num  (num[l]),
      .den  (den[l]),
      .res  (res_y[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        flow_r[k] <= '0;
      end
    end else if (adv) begin
      flow_r[0] <= flow_sel;
      for (int k = 1; k < LAT; k++) begin
        flow_r[k] <= flow_r[k-1];
      end
    end
  end

  assign out_tvalid = flow_r[LAT-1].vld;
  assign out_tuser  = flow_r[LAT-1].hit;
  assign out_tdata  = OUT_W'({res_y[1], res_x[1], res_y[0], res_x[0]});

endmodule

@@ sv/tps_select.sv @@
// ----------------------------------------------------------------------------
// tps_select
// Two stages: classify the triangle against z = 0, then pick the negative
// and positive end of each crossing edge and form numerator, divisor and
// coordinate spans for the interpolators.
// ----------------------------------------------------------------------------
module tps_select #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic signed [W-1:0]   a_x,
  input  logic signed [W-1:0]   a_y,
  input  logic signed [W-1:0]   a_z,
  input  logic signed [W-1:0]   b_x,
  input  logic signed [W-1:0]   b_y,
  input  logic signed [W-1:0]   b_z,
  input  logic signed [W-1:0]   c_x,
  input  logic signed [W-1:0]   c_y,
  input  logic signed [W-1:0]   c_z,
  output tps_pkg::tps_flow_t    flow,
  output logic        [W-1:0]   base_x [2],
  output logic        [W-1:0]   base_y [2],
  output logic                  neg_x  [2],
  output logic                  neg_y  [2],
  output logic        [W-1:0]   mag_x  [2],
  output logic        [W-1:0]   mag_y  [2],
  output logic        [W-1:0]   num    [2],
  output logic        [W-1:0]   den    [2]
);

  // stage A
  logic signed [W-1:0] a_x_r, a_y_r, a_z_r, b_x_r, b_y_r, b_z_r, c_x_r, c_y_r, c_z_r;
  tps_pkg::tps_pt_t    cs_r, cs_nxt, ce_r, ce_nxt;
  tps_pkg::tps_flow_t  fa_r, fa_nxt;
  // stage B
  tps_pkg::tps_flow_t  fb_r;

  logic za, zb, zc, sa, sb, sc;

  always_comb begin
    za = (a_z == '0);
    zb = (b_z == '0);
    zc = (c_z == '0);
    sa = a_z[W-1];
    sb = b_z[W-1];
    sc = c_z[W-1];
    fa_nxt.vld = in_vld;
    fa_nxt.hit = 1'b0;
    cs_nxt     = tps_pkg::PT_VA;
    ce_nxt     = tps_pkg::PT_VA;
    priority if (za && zb && zc) begin
      fa_nxt.hit = 1'b0;
    end else if (za && zb) begin
      fa_nxt.hit = 1'b1; cs_nxt = tps_pkg::PT_VA; ce_nxt = tps_pkg::PT_VB;
    end else if (zb && zc) begin
      fa_nxt.hit = 1'b1; cs_nxt = tps_pkg::PT_VB; ce_nxt = tps_pkg::PT_VC;
    end else if (zc && za) begin
      fa_nxt.hit = 1'b1; cs_nxt = tps_pkg::PT_VC; ce_nxt = tps_pkg::PT_VA;
    end else if (za) begin
      fa_nxt.hit = (sb != sc); cs_nxt = tps_pkg::PT_VA; ce_nxt = tps_pkg::PT_BC;
    end else if (zb) begin
      fa_nxt.hit = (sa != sc); cs_nxt = tps_pkg::PT_VB; ce_nxt = tps_pkg::PT_CA;
    end else if (zc) begin
      fa_nxt.hit = (sa != sb); cs_nxt = tps_pkg::PT_VC; ce_nxt = tps_pkg::PT_AB;
    end else if (sa != sb) begin
      fa_nxt.hit = 1'b1; cs_nxt = tps_pkg::PT_AB;
      ce_nxt = (sb != sc) ? tps_pkg::PT_BC : tps_pkg::PT_CA;
    end else if (sb != sc) begin
      fa_nxt.hit = 1'b1; cs_nxt = tps_pkg::PT_BC; ce_nxt = tps_pkg::PT_CA;
    end else begin
      fa_nxt.hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r <= '0;
      fb_r <= '0;
    end else if (adv) begin
      fa_r <= fa_nxt;
      fb_r <= fa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r <= a_x; a_y_r <= a_y; a_z_r <= a_z;
      b_x_r <= b_x; b_y_r <= b_y; b_z_r <= b_z;
      c_x_r <= c_x; c_y_r <= c_y; c_z_r <= c_z;
      cs_r  <= cs_nxt;
      ce_r  <= ce_nxt;
    end
  end

  assign flow = fb_r;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    tps_pkg::tps_pt_t    code;
    logic signed [W-1:0] p_x, p_y, p_z, q_x, q_y, q_z;
    logic signed [W-1:0] g_x, g_y, g_z, h_x, h_y, h_z;
    logic signed [W:0]   du_x, du_y, dz, nz;
    logic                is_vert;
    logic [W-1:0] base_x_r, base_x_nxt, base_y_r, base_y_nxt;
    logic [W-1:0] mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
    logic [W-1:0] num_r, num_nxt, den_r, den_nxt;
    logic         neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;

    assign code = (l == 0) ? cs_r : ce_r;

    always_comb begin
      is_vert = 1'b0;
      unique case (code)
        tps_pkg::PT_VA: begin
          is_vert = 1'b1;
          p_x = a_x_r; p_y = a_y_r; p_z = a_z_r; q_x = a_x_r; q_y = a_y_r; q_z = a_z_r;
        end
        tps_pkg::PT_VB: begin
          is_vert = 1'b1;
          p_x = b_x_r; p_y = b_y_r; p_z = b_z_r; q_x = b_x_r; q_y = b_y_r; q_z = b_z_r;
        end
        tps_pkg::PT_VC: begin
          is_vert = 1'b1;
          p_x = c_x_r; p_y = c_y_r; p_z = c_z_r; q_x = c_x_r; q_y = c_y_r; q_z = c_z_r;
        end
        tps_pkg::PT_AB: begin
          p_x = a_x_r; p_y = a_y_r; p_z = a_z_r; q_x = b_x_r; q_y = b_y_r; q_z = b_z_r;
        end
        tps_pkg::PT_BC: begin
          p_x = b_x_r; p_y = b_y_r; p_z = b_z_r; q_x = c_x_r; q_y = c_y_r; q_z = c_z_r;
        end
        tps_pkg::PT_CA: begin
          p_x = c_x_r; p_y = c_y_r; p_z = c_z_r; q_x = a_x_r; q_y = a_y_r; q_z = a_z_r;
        end
        default: begin
          p_x = '0; p_y = '0; p_z = '0; q_x = '0; q_y = '0; q_z = '0;
        end
      endcase

      // interpolate from the negative end: g is negative, h is positive
      if (p_z[W-1]) begin
        g_x = p_x; g_y = p_y; g_z = p_z; h_x = q_x; h_y = q_y; h_z = q_z;
      end else begin
        g_x = q_x; g_y = q_y; g_z = q_z; h_x = p_x; h_y = p_y; h_z = p_z;
      end

      du_x = {h_x[W-1], h_x} - {g_x[W-1], g_x};
      du_y = {h_y[W-1], h_y} - {g_y[W-1], g_y};
      dz   = {h_z[W-1], h_z} - {g_z[W-1], g_z};
      nz   = -{g_z[W-1], g_z};

      if (!fa_r.hit) begin
        base_x_nxt = '0;
        base_y_nxt = '0;
      end else if (is_vert) begin
        base_x_nxt = p_x;
        base_y_nxt = p_y;
      end else begin
        base_x_nxt = g_x;
        base_y_nxt = g_y;
      end

      // a vertex or a miss goes through the divider as 0 / 1
      if (!fa_r.hit || is_vert) begin
        neg_x_nxt = 1'b0;
        neg_y_nxt = 1'b0;
        mag_x_nxt = '0;
        mag_y_nxt = '0;
        num_nxt   = '0;
        den_nxt   = W'(1);
      end else begin
        neg_x_nxt = du_x[W];
        neg_y_nxt = du_y[W];
        mag_x_nxt = du_x[W] ? W'(-du_x) : du_x[W-1:0];
        mag_y_nxt = du_y[W] ? W'(-du_y) : du_y[W-1:0];
        num_nxt   = nz[W-1:0];
        den_nxt   = dz[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        base_x_r <= base_x_nxt;
        base_y_r <= base_y_nxt;
        neg_x_r  <= neg_x_nxt;
        neg_y_r  <= neg_y_nxt;
        mag_x_r  <= mag_x_nxt;
        mag_y_r  <= mag_y_nxt;
        num_r    <= num_nxt;
        den_r    <= den_nxt;
      end
    end

    assign base_x[l] = base_x_r;
    assign base_y[l] = base_y_r;
    assign neg_x[l]  = neg_x_r;
    assign neg_y[l]  = neg_y_r;
    assign mag_x[l]  = mag_x_r;
    assign mag_y[l]  = mag_y_r;
    assign num[l]    = num_r;
    assign den[l]    = den_r;
  end

endmodule

@@ sv/tps_interp.sv @@
// ----------------------------------------------------------------------------
// tps_interp
// One coordinate of a crossing: base +/- trunc(num * mag / den), with a
// registered multiply, a restoring divider of one quotient bit per stage
// and a registered final add.
// ----------------------------------------------------------------------------
module tps_interp #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] base,
  input  logic         neg,
  input  logic [W-1:0] mag,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] res
);

  logic [2*W-1:0] prod_r;
  logic [W-1:0]   den_m_r, base_m_r;
  logic           neg_m_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= num * mag;
      den_m_r  <= den;
      base_m_r <= base;
      neg_m_r  <= neg;
    end
  end

  // num < den, so the quotient stays below mag and fits W bits
  logic [W-1:0] rem_r  [W];
  logic [W-1:0] lo_r   [W];
  logic [W-1:0] quo_r  [W];
  logic [W-1:0] den_r  [W];
  logic [W-1:0] base_r [W];
  logic         neg_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W-1:0] rem_in, lo_in, quo_in, den_in, base_in;
    logic         neg_in;
    logic [W:0]   trial;
    logic [W-1:0] rem_nxt, quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = prod_r[2*W-1:W];
      assign lo_in   = prod_r[W-1:0];
      assign quo_in  = '0;
      assign den_in  = den_m_r;
      assign base_in = base_m_r;
      assign neg_in  = neg_m_r;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign lo_in   = lo_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign base_in = base_r[k-1];
      assign neg_in  = neg_r[k-1];
    end

    always_comb begin
      trial = {rem_in, lo_in[W-1]};
      if (trial >= {1'b0, den_in}) begin
        rem_nxt = W'(trial - {1'b0, den_in});
        quo_nxt = {quo_in[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_in[W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        lo_r[k]   <= {lo_in[W-2:0], 1'b0};
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        base_r[k] <= base_in;
        neg_r[k]  <= neg_in;
      end
    end
  end

  logic [W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= neg_r[W-1] ? base_r[W-1] - quo_r[W-1] : base_r[W-1] + quo_r[W-1];
    end
  end

  assign res = res_r;

endmodule

@@ bench/triangle_plane_section_core_tb.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_section_core_tb
// Self-checking bench for the triangle plane section core: directed corner
// triangles, then random triangles biased toward small and zero heights.
// Each result is compared with a behavioral prediction of the section.
// ----------------------------------------------------------------------------
module triangle_plane_section_core_tb;

  localparam int CB = 32;
  localparam int IW = ((9*CB+7)/8)*8;
  localparam int OW = ((4*CB+7)/8)*8;

  typedef struct {
    logic          hit;
    logic [CB-1:0] sx, sy, ex, ey;
  } section_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [IW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [OW-1:0] out_tdata;
  logic          out_tuser;

  section_t expected_sections[$];
  int       mismatches = 0;
  bit       calm = 0;

  triangle_plane_section_core #(.COORD_BITS(CB)) DUT (.*);

  always #4 clk = ~clk;

  // exact interpolation from the negative-z end, truncated toward zero
  function automatic logic signed [CB-1:0] interp(logic signed [CB-1:0] pn,
      logic signed [CB-1:0] pp, logic signed [CB-1:0] zn, logic signed [CB-1:0] zp);
    logic signed [127:0] du, num, den, q;
    du  = 128'(pp) - 128'(pn);
    num = -128'(zn) * du;
    den = 128'(zp) - 128'(zn);
    q   = num / den;
    return CB'(128'(pn) + q);
  endfunction

  function automatic bit opp(logic signed [CB-1:0] p, logic signed [CB-1:0] q);
    return (p < 0 && q > 0) || (p > 0 && q < 0);
  endfunction

  // crossing point of edge p-q, whose heights have strict opposite signs
  function automatic void edge_cross(logic signed [CB-1:0] p[3],
      logic signed [CB-1:0] q[3], output logic [CB-1:0] ox, output logic [CB-1:0] oy);
    if (p[2] > 0) begin
      ox = interp(q[0], p[0], q[2], p[2]);
      oy = interp(q[1], p[1], q[2], p[2]);
    end else begin
      ox = interp(p[0], q[0], p[2], q[2]);
      oy = interp(p[1], q[1], p[2], q[2]);
    end
  endfunction

  function automatic section_t section_of(logic [IW-1:0] d);
    logic signed [CB-1:0] a[3], b[3], c[3];
    section_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = d[i*CB +: CB];
      b[i] = d[(3+i)*CB +: CB];
      c[i] = d[(6+i)*CB +: CB];
    end
    r = '{1'b0, '0, '0, '0, '0};
    if (a[2] == 0 && b[2] == 0 && c[2] == 0) begin
      r.hit = 0;
    end else if (a[2] == 0 && b[2] == 0) begin
      r = '{1'b1, a[0], a[1], b[0], b[1]};
    end else if (b[2] == 0 && c[2] == 0) begin
      r = '{1'b1, b[0], b[1], c[0], c[1]};
    end else if (c[2] == 0 && a[2] == 0) begin
      r = '{1'b1, c[0], c[1], a[0], a[1]};
    end else if (a[2] == 0) begin
      if (opp(b[2], c[2])) begin
        r.hit = 1; r.sx = a[0]; r.sy = a[1]; edge_cross(b, c, r.ex, r.ey);
      end
    end else if (b[2] == 0) begin
      if (opp(a[2], c[2])) begin
        r.hit = 1; r.sx = b[0]; r.sy = b[1]; edge_cross(a, c, r.ex, r.ey);
      end
    end else if (c[2] == 0) begin
      if (opp(a[2], b[2])) begin
        r.hit = 1; r.sx = c[0]; r.sy = c[1]; edge_cross(a, b, r.ex, r.ey);
      end
    end else if (opp(a[2], b[2])) begin
      r.hit = 1;
      edge_cross(a, b, r.sx, r.sy);
      if (opp(b[2], c[2])) edge_cross(b, c, r.ex, r.ey);
      else edge_cross(c, a, r.ex, r.ey);
    end else if (opp(b[2], c[2])) begin
      r.hit = 1;
      edge_cross(b, c, r.sx, r.sy);
      edge_cross(c, a, r.ex, r.ey);
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return CB'($urandom);
      1: return {1'b1, {(CB-1){1'b0}}};
      2: return {1'b0, {(CB-1){1'b1}}};
      default: return CB'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic logic [CB-1:0] rnd_height();
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return CB'($urandom);
      3: return {1'b1, {(CB-1){1'b0}}};
      4: return {1'b0, {(CB-1){1'b1}}};
      5: return CB'($signed($urandom_range(0, 8)) - 4);
      default: return CB'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic send_triangle(logic [CB-1:0] v[9]);
    logic [IW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CB +: CB] = v[i];
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    expected_sections.push_back(section_of(d));
    @(negedge clk);
  endtask

  task automatic send_idle();
    in_tvalid <= 1'b0;
  endtask

  task automatic test_corners();
    logic [CB-1:0] mx, mn, one;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    one = CB'(32'h10000);
    send_triangle('{1, 2, 0, 3, 4, 0, 5, 6, 0});                // flat
    send_triangle('{mx, mn, 0, mn, mx, 0, 7, 8, one});          // edge ab in plane
    send_triangle('{1, 2, one, mx, mn, 0, mn, mx, 0});          // edge bc in plane
    send_triangle('{mn, mn, 0, 5, 5, -one, mx, mx, 0});         // edge ca in plane
    send_triangle('{9, 9, 0, mn, mn, mn, mx, mx, mx});          // vertex a, crossing bc
    send_triangle('{mx, mn, mx, 3, 3, 0, mn, mx, mn});          // vertex b, crossing ca
    send_triangle('{mn, mx, mn, mx, mn, 1, 4, 4, 0});           // vertex c, crossing ab
    send_triangle('{0, 0, 0, 1, 1, one, 2, 2, one});            // vertex touch, miss
    send_triangle('{0, 0, -one, one, one, one, 0, one, one});   // ab and ca cross
    send_triangle('{0, 0, -one, one, one, one, 0, one, -one});  // ab and bc cross
    send_triangle('{0, 0, one, one, one, -one, 0, one, one});   // ab and bc cross
    send_triangle('{0, 0, one, one, one, one, 0, one, -1});     // bc and ca cross
    send_triangle('{5, 5, 1, 6, 6, 2, 7, 7, mx});               // all above
    send_triangle('{5, 5, -1, 6, 6, mn, 7, 7, -2});             // all below
    send_triangle('{mn, mx, -1, mx, mn, mx, 0, 0, mx});         // steep cross
    send_triangle('{-1, -1, mn, mx, mx, mx, -1, 0, 1});         // widest span
  endtask

  task automatic test_random(int n);
    logic [CB-1:0] v[9];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) v[i] = (i % 3 == 2) ? rnd_height() : rnd_coord();
      send_triangle(v);
    end
  endtask

  task automatic test_full_rate(int n);
    calm = 1;
    test_random(n);
  endtask

  // result side: random backpressure, compare against oldest prediction
  always @(negedge clk) begin
    if (rst_n && !calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    out_tready <= rst_n;
  end

  always @(posedge clk) begin
    section_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sections.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h hit %b", out_tdata, out_tuser);
      end else begin
        e = expected_sections.pop_front();
        if (out_tuser !== e.hit || out_tdata[0 +: CB] !== e.sx ||
            out_tdata[CB +: CB] !== e.sy || out_tdata[2*CB +: CB] !== e.ex ||
            out_tdata[3*CB +: CB] !== e.ey) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %b seg %h %h %h %h, got hit %b seg %h %h %h %h",
                     e.hit, e.sx, e.sy, e.ex, e.ey, out_tuser, out_tdata[0 +: CB],
                     out_tdata[CB +: CB], out_tdata[2*CB +: CB], out_tdata[3*CB +: CB]);
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_corners();
    test_random(1800);
    test_full_rate(200);
    send_idle();
    while (expected_sections.size() != 0) @(negedge clk);
    repeat (CB + 20) @(negedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
sv/tps_pkg.sv
sv/tps_select.sv
sv/tps_interp.sv
sv/triangle_plane_section_core.sv
bench/triangle_plane_section_core_tb.sv
